FILE: rtl/idf_pkg.sv
`default_nettype none

package idf_pkg;

   // queue geometry
   localparam int DEPTH       = 16;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 4;
   localparam int COUNT_OUT_W = 5;
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int WIDE_W      = (COUNT_W > COUNT_OUT_W) ? COUNT_W : COUNT_OUT_W;
   localparam int SUM_W       = WIDE_W + 1;

   // operation codes
   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_READ   = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // controller to datapath strobes
   typedef struct packed {
      logic latch;
      logic exec;
      logic fetch;
      logic shift;
      logic finish;
   } dp_cmd_type;

   // datapath to controller flags
   typedef struct packed {
      logic is_push;
      logic is_read;
      logic err;
      logic more_first;
      logic more_next;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

FILE: rtl/idf_if.sv
`default_nettype none

// request channel
interface idf_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 op;
   logic signed [31:0]         push_value;
   logic [3:0]                 position;

   modport source (output valid, output op, output push_value, output position,
                   input ready);
   modport sink   (input valid, input op, input push_value, input position,
                   output ready);
endinterface

// response channel
interface idf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic signed [31:0]         result_value;
   logic [4:0]                 count_after;
   logic [1:0]                 status;

   modport source (output valid, output result_value, output count_after,
                   output status, input ready);
   modport sink   (input valid, input result_value, input count_after,
                   input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/idf_datapath.sv
`default_nettype none

module idf_datapath
   import idf_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dp_cmd_type                cmd,
   output dp_stat_type                    stat,
   input  wire logic [1:0]                req_op,
   input  wire logic signed [VALUE_W-1:0] req_push_value,
   input  wire logic [POS_W-1:0]          req_position,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [VALUE_W-1:0]      rsp_result_value,
   output logic [COUNT_OUT_W-1:0]         rsp_count_after,
   output logic [1:0]                     rsp_status
);

   // entry storage, head at slot 0
   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rdata_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  waddr;
   logic [VALUE_W-1:0] wdata;
   logic [ADDR_W-1:0]  raddr;

   logic [1:0]                 op_ff, op_in;
   logic signed [VALUE_W-1:0]  val_ff, val_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [COUNT_W-1:0]         occ_ff, occ_in;
   logic [ADDR_W-1:0]          idx_ff, idx_in;
   logic signed [VALUE_W-1:0]  res_ff, res_in;
   status_type                 code_ff, code_in;
   logic                       out_valid_ff, out_valid_in;
   logic signed [VALUE_W-1:0]  out_value_ff, out_value_in;
   logic [COUNT_OUT_W-1:0]     out_count_ff, out_count_in;
   status_type                 out_code_ff, out_code_in;

   op_type             op_q;
   logic [SUM_W-1:0]   eff_pos;
   logic [SUM_W-1:0]   occ_wide;
   logic [SUM_W-1:0]   idx_wide;
   logic [SUM_W-1:0]   count_wide;
   logic               full;
   logic               range_err;

   // precondition checks on the held request
   always_comb begin
      op_q       = op_type'(op_ff);
      occ_wide   = SUM_W'(occ_ff);
      idx_wide   = SUM_W'(idx_ff);
      count_wide = SUM_W'(occ_ff);
      eff_pos    = (op_q == OP_POP) ? '0 : SUM_W'(pos_ff);
      full       = (occ_ff == COUNT_W'(DEPTH));
      range_err  = (eff_pos >= occ_wide);
   end

   assign stat.is_push    = (op_q == OP_PUSH);
   assign stat.is_read    = (op_q == OP_READ);
   assign stat.err        = (op_q == OP_PUSH) ? full : range_err;
   assign stat.more_first = ((idx_wide + SUM_W'(1)) < occ_wide);
   assign stat.more_next  = ((idx_wide + SUM_W'(2)) < occ_wide);
   assign stat.out_free   = !out_valid_ff || rsp_ready;

   // next-state and memory port control
   always_comb begin
      op_in        = op_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      occ_in       = occ_ff;
      idx_in       = idx_ff;
      res_in       = res_ff;
      code_in      = code_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_count_in = out_count_ff;
      out_code_in  = out_code_ff;
      mem_we       = 1'b0;
      waddr        = idx_ff;
      wdata        = rdata_ff;
      raddr        = idx_ff;

      if (cmd.latch) begin
         op_in  = req_op;
         val_in = req_push_value;
         pos_in = req_position;
      end

      if (cmd.exec) begin
         res_in  = '0;
         code_in = ST_OK;
         if (op_q == OP_PUSH) begin
            if (full) begin
               code_in = ST_FULL;
            end else begin
               mem_we = 1'b1;
               waddr  = occ_ff[ADDR_W-1:0];
               wdata  = val_ff;
               occ_in = occ_ff + COUNT_W'(1);
            end
         end else if (range_err) begin
            code_in = ST_RANGE;
         end else begin
            raddr  = eff_pos[ADDR_W-1:0];
            idx_in = eff_pos[ADDR_W-1:0];
         end
      end

      // word at the position is now in the read register
      if (cmd.fetch) begin
         res_in = rdata_ff;
         if (op_q != OP_READ) begin
            if (stat.more_first) begin
               raddr = ADDR_W'(idx_wide + SUM_W'(1));
            end else begin
               occ_in = occ_ff - COUNT_W'(1);
            end
         end
      end

      // move one entry toward the head while the next read is under way
      if (cmd.shift) begin
         mem_we = 1'b1;
         waddr  = idx_ff;
         wdata  = rdata_ff;
         idx_in = idx_ff + ADDR_W'(1);
         if (stat.more_next) begin
            raddr = ADDR_W'(idx_wide + SUM_W'(2));
         end else begin
            occ_in = occ_ff - COUNT_W'(1);
         end
      end

      // output register
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         out_valid_in = 1'b1;
         out_value_in = res_ff;
         out_count_in = count_wide[COUNT_OUT_W-1:0];
         out_code_in  = code_ff;
      end
   end

   // storage with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      val_ff       <= val_in;
      pos_ff       <= pos_in;
      idx_ff       <= idx_in;
      res_ff       <= res_in;
      code_ff      <= code_in;
      out_value_ff <= out_value_in;
      out_count_ff <= out_count_in;
      out_code_ff  <= out_code_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_count_after  = out_count_ff;
   assign rsp_status       = out_code_ff;

endmodule

`default_nettype wire

FILE: rtl/idf_controller.sv
`default_nettype none

module idf_controller
   import idf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output dp_cmd_type       cmd,
   input  wire dp_stat_type stat
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_FETCH = 5'b00100,
      S_SHIFT = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // sequencing of one operation
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.err || stat.is_push) begin
               state_in = S_DONE;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            if (stat.is_read || !stat.more_first) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (!stat.more_next) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/indexed_delete_fifo.sv
// Ordered queue of up to DEPTH signed words with push, pop, read at a
// position and delete at a position; a delete closes the gap in order.
// Request channel req_ch carries op, push_value and position; response
// channel rsp_ch carries result_value, count_after and status. Each
// request beat yields exactly one response beat, in order.
// Requests are taken one at a time; a beat is accepted only while the
// sequencer is idle. The entries sit in a single-port-write, registered
// read memory, so an operation runs as a chain of steps: accept, check,
// fetch of the word at the position, one shift per entry moved toward
// the head (the entries behind the position), then the response load.
// A push or a failed check goes from the check straight to the load;
// a read goes from the fetch to the load and skips the shift steps.
// The sequencer goes back to idle as the response is loaded.
// A stalled receiver leaves the response in the output register; the
// sequencer waits in its final step until that register frees up.
// Reset empties the queue and drops any pending response; the storage
// itself is not cleared, since only slots below the count are read.
`default_nettype none

module indexed_delete_fifo
   import idf_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   idf_req_if.sink    req_ch,
   idf_rsp_if.source  rsp_ch
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   idf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   idf_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_ch.op),
      .req_push_value   (req_ch.push_value),
      .req_position     (req_ch.position),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_result_value (rsp_ch.result_value),
      .rsp_count_after  (rsp_ch.count_after),
      .rsp_status       (rsp_ch.status)
   );

endmodule

`default_nettype wire

FILE: rtl/idf_checker.sv
`default_nettype none

module idf_checker
   import idf_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic signed [31:0] rsp_result_value,
   input wire logic [4:0]        rsp_count_after,
   input wire logic [1:0]        rsp_status
);

   localparam logic [4:0] DEPTH_LOW = COUNT_OUT_W'(DEPTH);

   // a waiting response beat stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // no response right after reset
   a_reset_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // failed operations carry a zero word
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_RANGE || rsp_status == ST_FULL)
         |-> rsp_result_value == 0)
      else $error("nonzero word on failed operation");

   // full status only when the queue holds DEPTH entries
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count_after == DEPTH_LOW)
      else $error("full status with short queue");

   // status code stays within the defined set
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_RANGE
                     || rsp_status == ST_FULL))
      else $error("undefined status code");

endmodule

bind indexed_delete_fifo idf_checker u_idf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.result_value),
   .rsp_count_after  (rsp_ch.count_after),
   .rsp_status       (rsp_ch.status)
);

`default_nettype wire

FILE: sim/tb_indexed_delete_fifo.sv
`default_nettype none

module tb_indexed_delete_fifo;
   import idf_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 950;
   localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
   localparam int SCRIPT_ROWS  = 21;

   // one response beat as the queue should report it
   typedef struct packed {
      logic signed [VALUE_W-1:0]     value;
      logic [COUNT_OUT_W-1:0]        count;
      status_type                    status;
   } reply_type;

   // one row of the directed script; typed rows carry their own reply
   typedef struct packed {
      op_type                        op;
      logic signed [VALUE_W-1:0]     word;
      logic [POS_W-1:0]              pos;
      logic                          typed;
      reply_type                     reply;
   } script_row_type;

   // fill, drain and mixed bursts for the random part
   typedef enum int {
      MODE_FILL  = 0,
      MODE_DRAIN = 1,
      MODE_MIX   = 2
   } burst_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   idf_req_if req_ch ();
   idf_rsp_if rsp_ch ();

   indexed_delete_fifo dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // shadow copy of the queue contents
   logic signed [VALUE_W-1:0] queue_words [DEPTH];
   int                        queue_len = 0;

   reply_type                 pending_replies [$];
   reply_type                 oldest;
   script_row_type            script [SCRIPT_ROWS];

   logic                      steady = 1'b0;
   int                        mismatches = 0;
   int                        requests_sent = 0;
   int                        replies_checked = 0;
   int                        full_pushes = 0;
   int                        range_misses = 0;
   int                        inner_deletes = 0;
   int                        peak_len = 0;
   int                        idle_cycles = 0;
   int                        cycle_no = 0;

   always @(posedge clock) cycle_no <= cycle_no + 1;

   task automatic report_mismatch(input string what);
      $display("mismatch @%0d: %s", cycle_no, what);
      mismatches++;
   endtask

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // remove one slot and close the gap behind it
   function automatic logic signed [VALUE_W-1:0] take_entry(input int slot);
      logic signed [VALUE_W-1:0] w;
      int k;
      w = queue_words[slot];
      for (k = slot; k + 1 < queue_len; k++)
         queue_words[k] = queue_words[k + 1];
      queue_len--;
      return w;
   endfunction

   // apply one operation to the shadow queue and return its reply
   function automatic reply_type predict_reply(input op_type op,
                                               input logic signed [VALUE_W-1:0] word,
                                               input logic [POS_W-1:0] pos);
      reply_type r;
      r.value  = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (queue_len >= DEPTH) begin
               r.status = ST_FULL;
               full_pushes++;
            end else begin
               queue_words[queue_len] = word;
               queue_len++;
            end
         end
         OP_POP: begin
            if (queue_len == 0) begin
               r.status = ST_RANGE;
               range_misses++;
            end else begin
               r.value = take_entry(0);
            end
         end
         OP_READ: begin
            if (int'(pos) >= queue_len) begin
               r.status = ST_RANGE;
               range_misses++;
            end else begin
               r.value = queue_words[pos];
            end
         end
         default: begin
            if (int'(pos) >= queue_len) begin
               r.status = ST_RANGE;
               range_misses++;
            end else begin
               if (int'(pos) + 1 < queue_len) inner_deletes++;
               r.value = take_entry(int'(pos));
            end
         end
      endcase
      if (queue_len > peak_len) peak_len = queue_len;
      r.count = COUNT_OUT_W'(queue_len);
      return r;
   endfunction

   // drive one request beat and log its reply once accepted
   task automatic send_request(input op_type op,
                               input logic signed [VALUE_W-1:0] word,
                               input logic [POS_W-1:0] pos,
                               input logic typed,
                               input reply_type typed_reply);
      int gap;
      reply_type predicted;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= op;
      req_ch.push_value <= word;
      req_ch.position   <= pos;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      predicted = predict_reply(op, word, pos);
      pending_replies.push_back(typed ? typed_reply : predicted);
      requests_sent++;
   endtask

   // random word, with the extremes showing up often
   function automatic logic signed [VALUE_W-1:0] pick_word();
      case ($urandom_range(0, 11))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return 32'sh0000_0000;
         3:       return 32'shFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // position: mostly a live slot, otherwise anything
   function automatic logic [POS_W-1:0] pick_pos();
      if (queue_len > 0 && $urandom_range(0, 3) != 0)
         return POS_W'($urandom_range(0, queue_len - 1));
      return POS_W'($urandom_range(0, DEPTH - 1));
   endfunction

   function automatic op_type pick_op(input burst_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (r < 80) return OP_PUSH;
            return op_type'($urandom_range(1, 3));
         end
         MODE_DRAIN: begin
            if (r < 10) return OP_PUSH;
            if (r < 50) return OP_DELETE;
            if (r < 75) return OP_POP;
            return OP_READ;
         end
         default: return op_type'($urandom_range(0, 3));
      endcase
   endfunction

   // response side: runs of ready, broken by stalls
   initial begin
      int run;
      int stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         rsp_ch.ready <= 1'b1;
         run = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 10);
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected beat value=%0d count=%0d status=%0d",
                                      rsp_ch.result_value, rsp_ch.count_after,
                                      rsp_ch.status));
         end else begin
            oldest = pending_replies.pop_front();
            if (rsp_ch.result_value !== oldest.value)
               report_mismatch($sformatf("result_value %0d, want %0d",
                                         rsp_ch.result_value, oldest.value));
            if (rsp_ch.count_after !== oldest.count)
               report_mismatch($sformatf("count_after %0d, want %0d",
                                         rsp_ch.count_after, oldest.count));
            if (rsp_ch.status !== oldest.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_ch.status, oldest.status));
         end
         replies_checked++;
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
         $display("tb_indexed_delete_fifo NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus
   initial begin
      burst_mode_type mode;
      int burst;
      int sent_random;
      int i;

      // known values on every request input from time zero
      req_ch.valid      = 1'b0;
      req_ch.op         = OP_PUSH;
      req_ch.push_value = '0;
      req_ch.position   = '0;

      // empty queue, extremes, ordered removal, deleting the last entry
      script = '{
         '{OP_POP,    32'shDEAD_BEEF, 4'd0,  1'b1, '{32'sh0,          5'd0, ST_RANGE}},
         '{OP_READ,   32'sh0,         4'd0,  1'b1, '{32'sh0,          5'd0, ST_RANGE}},
         '{OP_DELETE, 32'sh0,         4'd15, 1'b1, '{32'sh0,          5'd0, ST_RANGE}},
         '{OP_PUSH,   32'sh7FFF_FFFF, 4'd15, 1'b1, '{32'sh0,          5'd1, ST_OK}},
         '{OP_PUSH,   32'sh8000_0000, 4'd0,  1'b1, '{32'sh0,          5'd2, ST_OK}},
         '{OP_READ,   32'sh0,         4'd0,  1'b1, '{32'sh7FFF_FFFF,  5'd2, ST_OK}},
         '{OP_READ,   32'shFFFF_FFFF, 4'd1,  1'b1, '{32'sh8000_0000,  5'd2, ST_OK}},
         '{OP_READ,   32'sh0,         4'd2,  1'b1, '{32'sh0,          5'd2, ST_RANGE}},
         '{OP_DELETE, 32'sh0,         4'd15, 1'b1, '{32'sh0,          5'd2, ST_RANGE}},
         '{OP_PUSH,   32'shFFFF_FFFF, 4'd0,  1'b1, '{32'sh0,          5'd3, ST_OK}},
         '{OP_PUSH,   32'sh0000_0001, 4'd0,  1'b1, '{32'sh0,          5'd4, ST_OK}},
         '{OP_DELETE, 32'sh0,         4'd1,  1'b1, '{32'sh8000_0000,  5'd3, ST_OK}},
         '{OP_READ,   32'sh0,         4'd1,  1'b1, '{32'shFFFF_FFFF,  5'd3, ST_OK}},
         '{OP_POP,    32'sh0,         4'd0,  1'b1, '{32'sh7FFF_FFFF,  5'd2, ST_OK}},
         '{OP_PUSH,   32'sh5A5A_A5A5, 4'd0,  1'b0, '{32'sh0,          5'd0, ST_OK}},
         '{OP_DELETE, 32'sh0,         4'd2,  1'b1, '{32'sh5A5A_A5A5,  5'd2, ST_OK}},
         '{OP_POP,    32'sh0,         4'd0,  1'b1, '{32'shFFFF_FFFF,  5'd1, ST_OK}},
         '{OP_DELETE, 32'sh0,         4'd0,  1'b1, '{32'sh0000_0001,  5'd0, ST_OK}},
         '{OP_POP,    32'sh0,         4'd0,  1'b1, '{32'sh0,          5'd0, ST_RANGE}},
         '{OP_PUSH,   32'sh1234_5678, 4'd0,  1'b0, '{32'sh0,          5'd0, ST_OK}},
         '{OP_READ,   32'sh0,         4'd0,  1'b0, '{32'sh0,          5'd0, ST_OK}}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed script
      for (i = 0; i < SCRIPT_ROWS; i++)
         send_request(script[i].op, script[i].word, script[i].pos,
                      script[i].typed, script[i].reply);

      // random bursts that swing the queue between empty and full
      sent_random = 0;
      while (sent_random < RANDOM_ITEMS) begin
         mode   = burst_mode_type'($urandom_range(0, 2));
         steady = ($urandom_range(0, 3) == 0);
         burst  = $urandom_range(16, 48);
         for (i = 0; i < burst && sent_random < RANDOM_ITEMS; i++) begin
            send_request(pick_op(mode), pick_word(), pick_pos(), 1'b0, '0);
            sent_random++;
         end
      end
      steady = 1'b0;
      req_ch.valid <= 1'b0;

      // let the last responses come home
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run: %0d requests (%0d scripted), %0d responses checked, peak occupancy %0d",
               requests_sent, SCRIPT_ROWS, replies_checked, peak_len);
      $display("run: %0d pushes on a full queue, %0d out-of-range, %0d mid-queue deletes",
               full_pushes, range_misses, inner_deletes);
      if (mismatches == 0) begin
         $display("tb_indexed_delete_fifo OK");
      end else begin
         $display("tb_indexed_delete_fifo NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
